// ===== design/rwl_pkg.sv =====
// Shared types, codes and constants for the reader-writer lock unit.
// No dependencies; every other file of the block imports this package.
package rwl_pkg;

    // Width of the owner and waiter counters.
    localparam int COUNT_BITS = 10;
    // Width of the count fields on the result beat.
    localparam int OUT_BITS   = 10;
    localparam int WIDE_BITS  = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

    localparam int MODE_BITS  = 3;
    localparam int SPIN_BITS  = 16;
    localparam int STAT_BITS  = 3;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Stream payload widths, padded to whole bytes.
    localparam int S_DATA_BITS = ((MODE_BITS + SPIN_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = STAT_BITS + 1 + OUT_BITS + 1 + OUT_BITS;
    localparam int M_DATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ZERO = '0;
    localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
    localparam logic [OUT_BITS-1:0]   OUT_MAX  = '1;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [OUT_BITS-1:0]   out_count_t;

    // Request operation, decoded from the mode field.
    typedef enum logic [MODE_BITS-1:0] {
        OP_ACQ_EXCL  = 3'd0,
        OP_ACQ_SHRD  = 3'd1,
        OP_REL_EXCL  = 3'd2,
        OP_REL_SHRD  = 3'd3,
        OP_TRY_EXCL  = 3'd4,
        OP_TRY_SHRD  = 3'd5,
        OP_WAKE_DONE = 3'd6,
        OP_INVALID   = 3'd7
    } op_t;

    typedef enum logic [STAT_BITS-1:0] {
        ST_GRANTED = 3'd0,
        ST_RETRY   = 3'd1,
        ST_QUEUED  = 3'd2,
        ST_REFUSED = 3'd3,
        ST_FULL    = 3'd4,
        ST_MISUSE  = 3'd5
    } status_t;

    // Classified request as it travels from front to back.
    typedef struct packed {
        op_t  op;
        logic spin_done;   // attempt count has reached the spin limit
    } cmd_t;

    // Clip a counter value to the width of the result fields.
    function automatic out_count_t clip_out(input count_t v);
        logic [WIDE_BITS-1:0] wide;
        logic [WIDE_BITS-1:0] lim;
        wide = WIDE_BITS'(v);
        lim  = WIDE_BITS'(OUT_MAX);
        return (wide > lim) ? OUT_MAX : wide[OUT_BITS-1:0];
    endfunction

endpackage

// ===== design/rwl_front.sv =====
// Front end: accepts request beats, holds the spin limit register and
// classifies each request into a command. Depends on rwl_pkg.
module rwl_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rwl_pkg::SPIN_BITS-1:0]  cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rwl_pkg::S_DATA_BITS-1:0] s_tdata,
    output logic                           push_valid,
    input  logic                           push_ready,
    output rwl_pkg::cmd_t                  push_cmd
);
    import rwl_pkg::*;

    logic [SPIN_BITS-1:0] spin_limit_reg;
    logic [SPIN_BITS-1:0] spin_limit_next;
    logic [MODE_BITS-1:0] mode;
    logic [SPIN_BITS-1:0] attempt_count;

    assign cfg_ready = 1'b1;
    assign spin_limit_next = (cfg_valid) ? cfg_data : spin_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spin_limit_reg <= '0;
        end else begin
            spin_limit_reg <= spin_limit_next;
        end
    end

    assign mode          = s_tdata[MODE_BITS-1:0];
    assign attempt_count = s_tdata[MODE_BITS+SPIN_BITS-1:MODE_BITS];

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    always_comb begin
        push_cmd.op        = op_t'(mode);
        push_cmd.spin_done = (attempt_count >= spin_limit_reg);
    end

endmodule

// ===== design/rwl_queue.sv =====
// Short command queue decoupling the front end from the back end.
// Depends on rwl_pkg for the command type and depth.
module rwl_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  rwl_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output rwl_pkg::cmd_t out_cmd
);
    import rwl_pkg::*;

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 push, pop;

    assign in_ready  = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_BITS'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_BITS'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_BITS'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== design/rwl_back.sv =====
// Back end: applies one command per cycle to the lock state while the result
// register can take a beat, and registers the result beat. Depends on rwl_pkg.
module rwl_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  rwl_pkg::cmd_t                   cmd,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rwl_pkg::M_DATA_BITS-1:0] m_tdata
);
    import rwl_pkg::*;

    logic   owned_reg, owned_next;
    logic   waking_reg, waking_next;
    count_t readers_reg, readers_next;
    count_t sh_wait_reg, sh_wait_next;
    count_t ex_wait_reg, ex_wait_next;

    logic                   m_valid_reg, m_valid_next;
    logic [M_DATA_BITS-1:0] m_data_reg, m_data_next;

    status_t status;
    logic    wake_x;
    count_t  wake_s;
    logic    take;
    logic    ex_pending;

    // output register frees up when empty or being taken
    assign cmd_ready  = !m_valid_reg || m_tready;
    assign take       = cmd_valid && cmd_ready;
    assign ex_pending = waking_reg || (ex_wait_reg != CNT_ZERO);

    always_comb begin
        owned_next   = owned_reg;
        waking_next  = waking_reg;
        readers_next = readers_reg;
        sh_wait_next = sh_wait_reg;
        ex_wait_next = ex_wait_reg;
        status       = ST_MISUSE;
        wake_x       = 1'b0;
        wake_s       = CNT_ZERO;

        unique case (cmd.op)
            OP_ACQ_EXCL: begin
                if (!owned_reg && !waking_reg) begin
                    owned_next = 1'b1;
                    status     = ST_GRANTED;
                end else if (!cmd.spin_done) begin
                    status = ST_RETRY;
                end else if (ex_wait_reg == CNT_MAX) begin
                    status = ST_FULL;
                end else begin
                    ex_wait_next = ex_wait_reg + CNT_ONE;
                    status       = ST_QUEUED;
                end
            end
            OP_ACQ_SHRD, OP_TRY_SHRD: begin
                // shared grant first; a blocking acquire falls back to spin/queue
                if (!ex_pending && !owned_reg && readers_reg == CNT_ZERO) begin
                    owned_next   = 1'b1;
                    readers_next = CNT_ONE;
                    status       = ST_GRANTED;
                end else if (!ex_pending && owned_reg && readers_reg != CNT_ZERO) begin
                    if (readers_reg == CNT_MAX) begin
                        status = ST_FULL;
                    end else begin
                        readers_next = readers_reg + CNT_ONE;
                        status       = ST_GRANTED;
                    end
                end else if (cmd.op == OP_TRY_SHRD) begin
                    status = ST_REFUSED;
                end else if (!cmd.spin_done) begin
                    status = ST_RETRY;
                end else if (sh_wait_reg == CNT_MAX) begin
                    status = ST_FULL;
                end else begin
                    sh_wait_next = sh_wait_reg + CNT_ONE;
                    status       = ST_QUEUED;
                end
            end
            OP_REL_EXCL: begin
                if (owned_reg && readers_reg == CNT_ZERO) begin
                    if (ex_wait_reg != CNT_ZERO) begin
                        ex_wait_next = ex_wait_reg - CNT_ONE;
                        waking_next  = 1'b1;
                        wake_x       = 1'b1;
                    end else begin
                        wake_s       = sh_wait_reg;
                        sh_wait_next = CNT_ZERO;
                    end
                    owned_next = 1'b0;
                    status     = ST_GRANTED;
                end
            end
            OP_REL_SHRD: begin
                if (owned_reg && readers_reg != CNT_ZERO) begin
                    if (readers_reg != CNT_ONE) begin
                        readers_next = readers_reg - CNT_ONE;
                    end else begin
                        readers_next = CNT_ZERO;
                        owned_next   = 1'b0;
                        if (ex_wait_reg != CNT_ZERO) begin
                            ex_wait_next = ex_wait_reg - CNT_ONE;
                            waking_next  = 1'b1;
                            wake_x       = 1'b1;
                        end
                    end
                    status = ST_GRANTED;
                end
            end
            OP_TRY_EXCL: begin
                if (owned_reg || waking_reg) begin
                    status = ST_REFUSED;
                end else begin
                    owned_next = 1'b1;
                    status     = ST_GRANTED;
                end
            end
            OP_WAKE_DONE: begin
                if (waking_reg && !owned_reg && readers_reg == CNT_ZERO) begin
                    waking_next = 1'b0;
                    owned_next  = 1'b1;
                    status      = ST_GRANTED;
                end
            end
            OP_INVALID: begin
                status = ST_MISUSE;
            end
            default: begin
                status = ST_MISUSE;
            end
        endcase
    end

    // result beat: status, wake_exclusive, wake_shared_count, owned_now, readers_now
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (take) begin
            m_valid_next = 1'b1;
            m_data_next  = M_DATA_BITS'({clip_out(readers_next), owned_next,
                                         clip_out(wake_s), wake_x, status});
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owned_reg   <= 1'b0;
            waking_reg  <= 1'b0;
            readers_reg <= CNT_ZERO;
            sh_wait_reg <= CNT_ZERO;
            ex_wait_reg <= CNT_ZERO;
            m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                owned_reg   <= owned_next;
                waking_reg  <= waking_next;
                readers_reg <= readers_next;
                sh_wait_reg <= sh_wait_next;
                ex_wait_reg <= ex_wait_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== design/reader_writer_lock_unit.sv =====
// Top level of the reader-writer lock unit: front end, command queue, back end.
// Depends on rwl_pkg, rwl_front, rwl_queue and rwl_back.
//
// Hardware reader-writer lock with waiter counts. Every request beat on the
// s_ channel yields exactly one result beat on the m_ channel, in order.
// The block takes one request per cycle and keeps that rate as long as the
// result side takes one beat per cycle; an accepted request passes through the
// command queue and then the output register on its way to its result beat.
// The lock state (owned, waking, reader count, shared and exclusive waiter
// counts) lives in the back end and is updated once per request, which sets
// the one-per-cycle rate. The front end decodes the mode and compares the
// attempt count against spin_limit; a two-beat queue lets input and output
// stall independently. spin_limit resets to 0 and is written through the
// cfg_ channel, which is always ready; write it only while idle.
// Counts saturate with a "count full" status; mismatched releases and mode 7
// return "misuse" and leave the state untouched.
module reader_writer_lock_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration: spin_limit[15:0]
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rwl_pkg::SPIN_BITS-1:0]    cfg_data,
    // requests: mode[2:0], attempt_count[18:3], zero pad above
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rwl_pkg::S_DATA_BITS-1:0]  s_tdata,
    // results: status[2:0], wake_exclusive[3], wake_shared_count[13:4],
    //          owned_now[14], readers_now[24:15], zero pad above
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rwl_pkg::M_DATA_BITS-1:0]  m_tdata
);
    import rwl_pkg::*;

    logic push_valid, push_ready;
    cmd_t push_cmd;
    logic pop_valid, pop_ready;
    cmd_t pop_cmd;

    // decode and spin check
    rwl_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // decoupling queue
    rwl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_cmd    (push_cmd),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_cmd   (pop_cmd)
    );

    // lock state and result register
    rwl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== bench/reader_writer_lock_unit_tb.sv =====
// Self-checking bench for reader_writer_lock_unit: directed lock sequences
// and randomized sessions, scored against a predictor.
// Depends on rwl_pkg and the design files of reader_writer_lock_unit.
module reader_writer_lock_unit_tb;
    import rwl_pkg::*;

    localparam int RUN_LIMIT  = 600000;  // cycles before the run is declared hung
    localparam int RAND_ITEMS = 450;
    localparam int HOLD_LEN   = 64;      // long result-side stall, in cycles

    // result beat layout, lowest bit up
    localparam int WX_BIT = STAT_BITS;
    localparam int WS_LO  = WX_BIT + 1;
    localparam int OWN_BIT = WS_LO + OUT_BITS;
    localparam int RD_LO  = OWN_BIT + 1;
    localparam int M_USED = RD_LO + OUT_BITS;

    typedef struct {
        op_t               op;
        logic [SPIN_BITS-1:0] attempts;
    } lock_req_t;

    typedef struct {
        status_t    status;
        logic       wake_excl;
        out_count_t wake_shared;
        logic       owned;
        out_count_t readers;
    } lock_result_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [SPIN_BITS-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_BITS-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_BITS-1:0] m_tdata;

    reader_writer_lock_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Predicted lock state, advanced once per accepted request beat
    logic                 sh_owned  = 1'b0;
    logic                 sh_waking = 1'b0;
    count_t               sh_readers = '0;
    count_t               sh_swait   = '0;
    count_t               sh_xwait   = '0;
    logic [SPIN_BITS-1:0] sh_spin    = '0;

    lock_req_t    lock_reqs[$];     // requests waiting for the driver
    lock_result_t due_results[$];   // predicted result beats, oldest first

    int send_idle_pct = 18;
    int recv_idle_pct = 83;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int issued = 0;
    int errors = 0;
    int cycle_cnt = 0;

    logic                   rx_hit = 1'b0;
    logic [M_DATA_BITS-1:0] rx_word = '0;

    function automatic out_count_t fit_out(input count_t v);
        return (int'(v) > int'(OUT_MAX)) ? OUT_MAX : out_count_t'(v);
    endfunction

    // Blocked acquire: keep spinning below the limit, else join the waiters
    function automatic status_t spin_or_queue(input logic [SPIN_BITS-1:0] attempts,
                                              input logic shared_side);
        if (attempts < sh_spin)
            return ST_RETRY;
        if (shared_side) begin
            if (sh_swait == CNT_MAX)
                return ST_FULL;
            sh_swait = sh_swait + CNT_ONE;
        end else begin
            if (sh_xwait == CNT_MAX)
                return ST_FULL;
            sh_xwait = sh_xwait + CNT_ONE;
        end
        return ST_QUEUED;
    endfunction

    // Readers get in only with no writer pending and the lock free or reader-held
    function automatic status_t reader_grant();
        if (sh_waking || sh_xwait != CNT_ZERO)
            return ST_REFUSED;
        if (!sh_owned && sh_readers == CNT_ZERO) begin
            sh_owned = 1'b1;
            sh_readers = CNT_ONE;
            return ST_GRANTED;
        end
        if (sh_owned && sh_readers != CNT_ZERO) begin
            if (sh_readers == CNT_MAX)
                return ST_FULL;
            sh_readers = sh_readers + CNT_ONE;
            return ST_GRANTED;
        end
        return ST_REFUSED;  // held exclusive: reader is blocked
    endfunction

    function automatic lock_result_t lock_step(input lock_req_t rq);
        lock_result_t r;
        count_t woken;
        r.status = ST_MISUSE;
        r.wake_excl = 1'b0;
        woken = CNT_ZERO;
        case (rq.op)
            OP_ACQ_EXCL: begin
                if (!sh_owned && !sh_waking) begin
                    sh_owned = 1'b1;
                    r.status = ST_GRANTED;
                end else begin
                    r.status = spin_or_queue(rq.attempts, 1'b0);
                end
            end
            OP_ACQ_SHRD: begin
                r.status = reader_grant();
                if (r.status == ST_REFUSED)
                    r.status = spin_or_queue(rq.attempts, 1'b1);
            end
            OP_REL_EXCL: begin
                if (sh_owned && sh_readers == CNT_ZERO) begin
                    if (sh_xwait != CNT_ZERO) begin
                        sh_xwait = sh_xwait - CNT_ONE;
                        sh_waking = 1'b1;
                        r.wake_excl = 1'b1;
                    end else begin
                        woken = sh_swait;
                        sh_swait = CNT_ZERO;
                    end
                    sh_owned = 1'b0;
                    r.status = ST_GRANTED;
                end
            end
            OP_REL_SHRD: begin
                if (sh_owned && sh_readers != CNT_ZERO) begin
                    if (sh_readers > CNT_ONE) begin
                        sh_readers = sh_readers - CNT_ONE;
                    end else begin
                        sh_readers = CNT_ZERO;
                        sh_owned = 1'b0;
                        if (sh_xwait != CNT_ZERO) begin
                            sh_xwait = sh_xwait - CNT_ONE;
                            sh_waking = 1'b1;
                            r.wake_excl = 1'b1;
                        end
                    end
                    r.status = ST_GRANTED;
                end
            end
            OP_TRY_EXCL: begin
                if (sh_owned || sh_waking) begin
                    r.status = ST_REFUSED;
                end else begin
                    sh_owned = 1'b1;
                    r.status = ST_GRANTED;
                end
            end
            OP_TRY_SHRD: r.status = reader_grant();
            OP_WAKE_DONE: begin
                if (sh_waking && !sh_owned && sh_readers == CNT_ZERO) begin
                    sh_waking = 1'b0;
                    sh_owned = 1'b1;
                    r.status = ST_GRANTED;
                end
            end
            default: ;  // unknown mode: misuse, state untouched
        endcase
        r.wake_shared = fit_out(woken);
        r.owned = sh_owned;
        r.readers = fit_out(sh_readers);
        return r;
    endfunction

    // Driver: holds a beat until taken; prediction happens on acceptance
    always @(posedge aclk) begin : req_driver
        lock_req_t cur;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                cur = lock_reqs.pop_front();
                due_results.push_back(lock_step(cur));
            end
            if (!s_tvalid || s_tready) begin
                if (lock_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= S_DATA_BITS'({lock_reqs[0].attempts, lock_reqs[0].op});
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure plus an occasional long hold-off
    always @(posedge aclk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_LEN;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: capture each result beat at the rising edge, score it on the falling edge
    always @(posedge aclk) begin
        rx_hit <= aresetn && m_tvalid && m_tready;
        rx_word <= m_tdata;
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    always @(negedge aclk) begin : result_monitor
        lock_result_t want;
        if (rx_hit) begin
            if (due_results.size() == 0) begin
                $error("result beat %h with no request outstanding", rx_word);
                errors++;
            end else begin
                want = due_results.pop_front();
                check_field("status", int'(want.status), int'(rx_word[STAT_BITS-1:0]));
                check_field("wake_exclusive", int'(want.wake_excl), int'(rx_word[WX_BIT]));
                check_field("wake_shared_count", int'(want.wake_shared),
                            int'(rx_word[WS_LO +: OUT_BITS]));
                check_field("owned_now", int'(want.owned), int'(rx_word[OWN_BIT]));
                check_field("readers_now", int'(want.readers),
                            int'(rx_word[RD_LO +: OUT_BITS]));
                check_field("pad", 0, int'(rx_word >> M_USED));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == RUN_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [SPIN_BITS-1:0] rnd16();
        return SPIN_BITS'($urandom);
    endfunction

    // Attempt counts cluster around the spin limit so both retry and queue show up
    function automatic logic [SPIN_BITS-1:0] pick_attempts();
        case ($urandom_range(5))
            0: return sh_spin - 1'b1;
            1: return sh_spin;
            2: return sh_spin + 1'b1;
            3: return '0;
            4: return '1;
            default: return rnd16();
        endcase
    endfunction

    function automatic op_t pick_contender();
        case ($urandom_range(3))
            0: return OP_ACQ_EXCL;
            1: return OP_ACQ_SHRD;
            2: return OP_TRY_EXCL;
            default: return OP_TRY_SHRD;
        endcase
    endfunction

    task automatic send(input op_t op, input logic [SPIN_BITS-1:0] attempts);
        lock_req_t rq;
        rq.op = op;
        rq.attempts = attempts;
        lock_reqs.push_back(rq);
        issued++;
    endtask

    task automatic wait_accepted();
        while (lock_reqs.size() != 0)
            @(negedge aclk);
    endtask

    // Sender pause: nothing queued and every predicted beat seen
    task automatic drain_all();
        while (lock_reqs.size() != 0 || due_results.size() != 0)
            @(negedge aclk);
    endtask

    // Walk the lock back to free with no writer pending, one beat at a time
    task automatic settle_lock();
        wait_accepted();
        while (sh_owned || sh_waking || sh_xwait != CNT_ZERO) begin
            if (sh_waking && !sh_owned)
                send(OP_WAKE_DONE, rnd16());
            else if (sh_owned && sh_readers != CNT_ZERO)
                send(OP_REL_SHRD, rnd16());
            else if (sh_owned)
                send(OP_REL_EXCL, rnd16());
            else
                send(OP_TRY_EXCL, rnd16());
            wait_accepted();
        end
    endtask

    // Register write; only called with the block idle
    task automatic write_spin(input logic [SPIN_BITS-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sh_spin = v;
        @(negedge aclk);
    endtask

    initial begin
        int ph;
        int n;
        int goal;
        logic [SPIN_BITS-1:0] v;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed walk at the reset spin limit of zero: every blocked
        // acquire queues at once
        send(OP_TRY_EXCL, '0);
        send(OP_ACQ_SHRD, '1);        // reader queues behind the writer
        send(OP_TRY_SHRD, '0);        // held exclusive, no writer waiting
        send(OP_ACQ_EXCL, '0);        // writer queues
        send(OP_TRY_SHRD, '1);        // writer pending: refused
        send(OP_REL_SHRD, '0);        // no readers: misuse
        send(OP_WAKE_DONE, '1);       // no wake pending: misuse
        send(OP_REL_EXCL, '0);        // hand-off to the queued writer
        send(OP_ACQ_EXCL, '1);        // wake in flight: queues
        send(OP_TRY_EXCL, '0);        // wake in flight: refused
        send(OP_REL_EXCL, '1);        // not owned: misuse
        send(OP_WAKE_DONE, '0);
        send(OP_REL_EXCL, '1);        // second hand-off
        send(OP_WAKE_DONE, '1);
        send(OP_REL_EXCL, '0);        // no writer left: readers woken
        send(OP_INVALID, '1);
        send(OP_ACQ_SHRD, '0);
        send(OP_TRY_SHRD, '1);
        send(OP_REL_EXCL, '0);        // readers hold it: misuse
        send(OP_ACQ_EXCL, '1);
        send(OP_REL_SHRD, '0);
        send(OP_REL_SHRD, '1);        // last reader out wakes the writer
        send(OP_WAKE_DONE, '0);
        send(OP_REL_EXCL, '1);

        // Randomized sessions in three idle profiles, each at its own spin limit
        for (ph = 0; ph < 3; ph++) begin
            drain_all();
            settle_lock();
            drain_all();
            send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 83 : 0;
            recv_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 18 : 0;
            v = (ph == 0) ? SPIN_BITS'($urandom_range(1, 5)) :
                (ph == 1) ? '1 : SPIN_BITS'($urandom_range(2, 40));
            write_spin(v);
            // long hold on results while reader beats keep coming
            repeat (10) send(OP_TRY_SHRD, rnd16());
            repeat (10) send(OP_REL_SHRD, rnd16());
            hold_reqs++;
            goal = issued + RAND_ITEMS / 3;
            while (issued < goal) begin
                settle_lock();
                case ($urandom_range(9))
                    0, 1, 2, 3: begin
                        send($urandom_range(1) ? OP_ACQ_EXCL : OP_TRY_EXCL, pick_attempts());
                        repeat ($urandom_range(3)) send(pick_contender(), pick_attempts());
                        send(OP_REL_EXCL, rnd16());
                        if ($urandom_range(1))
                            send(OP_WAKE_DONE, rnd16());
                    end
                    4, 5, 6, 7: begin
                        n = $urandom_range(1, 4);
                        repeat (n) send($urandom_range(1) ? OP_ACQ_SHRD : OP_TRY_SHRD,
                                        pick_attempts());
                        repeat ($urandom_range(3)) send(pick_contender(), pick_attempts());
                        if ($urandom_range(3) == 0)
                            send(OP_REL_EXCL, rnd16());
                        repeat (n) send(OP_REL_SHRD, rnd16());
                    end
                    default: begin
                        repeat ($urandom_range(1, 3)) send(op_t'($urandom_range(7)), rnd16());
                    end
                endcase
                if ($urandom_range(7) == 0)
                    drain_all();
            end
        end

        drain_all();
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
